[sv/frd_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// frd_pkg
// Shared types and constants for the Fresnel refraction direction pipeline:
// the per-beat pipeline item, the stage schedule and the path codes.
// ----------------------------------------------------------------------------
package frd_pkg;

   localparam logic [1:0] PATH_TIR  = 2'd0;
   localparam logic [1:0] PATH_REFL = 2'd1;
   localparam logic [1:0] PATH_REFR = 2'd2;

   // stage schedule (index of the register that holds the stage's result)
   localparam int ST_IN     = 0;
   localparam int ST_COS    = 1;
   localparam int ST_CSQ    = 2;
   localparam int ST_S      = 3;
   localparam int ST_ETA0   = 1;
   localparam int ETA_STEPS = 19;
   localparam int ST_ETA    = ST_ETA0 + ETA_STEPS;
   localparam int ST_ETA2   = ST_ETA + 1;
   localparam int ST_M      = ST_ETA2 + 1;
   localparam int ST_SIN    = ST_M + 1;
   localparam int ST_SQ0    = ST_SIN + 1;
   localparam int SQ_STEPS  = 32;
   localparam int ST_PROD4  = ST_SQ0 + SQ_STEPS;
   localparam int ST_NUM    = ST_PROD4 + 1;
   localparam int ST_RSET   = ST_NUM + 1;
   localparam int ST_RAT0   = ST_RSET + 1;
   localparam int RAT_STEPS = 30;
   localparam int ST_SQR    = ST_RAT0 + RAT_STEPS;
   localparam int ST_PATH   = ST_SQR + 1;
   localparam int ST_OPROD  = ST_PATH + 1;
   localparam int ST_OSUM   = ST_OPROD + 1;
   localparam int ST_OSAT   = ST_OSUM + 1;
   localparam int DEPTH     = ST_OSAT + 1;

   typedef struct packed {
      logic [2:0][15:0]     v;
      logic [2:0][15:0]     n;
      logic [15:0]          n1;
      logic [15:0]          n2;
      logic [15:0]          draw;
      logic [2:0][31:0]     prod;
      logic signed [32:0]   c;
      logic [62:0]          cc;
      logic signed [33:0]   s;
      logic [15:0]          div_d;
      logic                 eta_sat;
      logic [34:0]          eta_rem;
      logic [18:0]          eta_q;
      logic [21:0]          eta2;
      logic signed [51:0]   ec;
      logic signed [35:0]   ec_t;
      logic [53:0]          m;
      logic                 tir;
      logic [62:0]          sq_x;
      logic [63:0]          sq_res;
      logic signed [49:0]   p_n1c;
      logic signed [49:0]   p_n2c;
      logic [47:0]          p_n2ct;
      logic [47:0]          p_n1ct;
      logic signed [35:0]   k;
      logic signed [50:0]   a_num;
      logic signed [50:0]   a_den;
      logic signed [50:0]   p_num;
      logic signed [50:0]   p_den;
      logic                 zero_den;
      logic                 ro_sat;
      logic                 rp_sat;
      logic [50:0]          ro_b;
      logic [50:0]          rp_b;
      logic [51:0]          ro_r;
      logic [51:0]          rp_r;
      logic [31:0]          ro_q;
      logic [31:0]          rp_q;
      logic [63:0]          ro_sq;
      logic [63:0]          rp_sq;
      logic [1:0]           path;
      logic [2:0][35:0]     pv;
      logic [2:0][51:0]     pk;
      logic [2:0][48:0]     pc;
      logic [2:0][23:0]     tz;
      logic [2:0][15:0]     res;
   } frd_item_type;

endpackage
`default_nettype wire

[sv/fresnel_refract_direction_core.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// fresnel_refract_direction_core
// Picks reflection or refraction of a ray at a dielectric surface from the
// exact Fresnel reflectance and a random draw, and returns the new direction.
// ----------------------------------------------------------------------------
// An accepted req beat passes through every stage register to its rsp beat.
// Throughput: one beat per cycle; the depth is set by the eta divider, the
// 32-step square root and the two 30-step reflectance dividers, one step each.
// A held rsp beat stalls the whole pipeline; nothing is dropped or repeated.
// Reset clears the stage valid bits only.
module fresnel_refract_direction_core #(
   parameter int COMPONENT_FRAC_BITS = 14
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic signed [15:0] req_incident_x,
   input  logic signed [15:0] req_incident_y,
   input  logic signed [15:0] req_incident_z,
   input  logic signed [15:0] req_normal_x,
   input  logic signed [15:0] req_normal_y,
   input  logic signed [15:0] req_normal_z,
   input  logic [15:0]        req_index_from,
   input  logic [15:0]        req_index_to,
   input  logic [15:0]        req_random_draw,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [15:0] rsp_result_x,
   output logic signed [15:0] rsp_result_y,
   output logic signed [15:0] rsp_result_z,
   output logic [1:0]         rsp_path_taken
);
   import frd_pkg::*;

   frd_item_type item_w [0:DEPTH];
   logic         vld_w  [0:DEPTH];
   frd_item_type item0;
   logic         adv;

   always_comb begin
      item0      = '0;
      item0.v[0] = req_incident_x;
      item0.v[1] = req_incident_y;
      item0.v[2] = req_incident_z;
      item0.n[0] = req_normal_x;
      item0.n[1] = req_normal_y;
      item0.n[2] = req_normal_z;
      item0.n1   = req_index_from;
      item0.n2   = req_index_to;
      item0.draw = req_random_draw;
   end

   assign adv       = !vld_w[DEPTH] || rsp_ready;
   assign req_ready = adv;
   assign item_w[0] = item0;
   assign vld_w[0]  = req_valid;

   for (genvar g = 0; g < DEPTH; g++) begin : g_stage
      frd_stage #(
         .STAGE     (g),
         .FRAC_BITS (COMPONENT_FRAC_BITS)
      ) u_stage (
         .clock     (clock),
         .reset     (reset),
         .adv       (adv),
         .in_valid  (vld_w[g]),
         .in_item   (item_w[g]),
         .out_valid (vld_w[g + 1]),
         .out_item  (item_w[g + 1])
      );
   end

   assign rsp_valid      = vld_w[DEPTH];
   assign rsp_result_x   = $signed(item_w[DEPTH].res[0]);
   assign rsp_result_y   = $signed(item_w[DEPTH].res[1]);
   assign rsp_result_z   = $signed(item_w[DEPTH].res[2]);
   assign rsp_path_taken = item_w[DEPTH].path;

   a_stall_blocks_req: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready)
      else $error("req_ready high while output beat is held");

   a_tir_path: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && item_w[DEPTH].tir |-> rsp_path_taken == PATH_TIR)
      else $error("total internal reflection not reported");

   a_zero_den_path: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !item_w[DEPTH].tir && item_w[DEPTH].zero_den
      |-> rsp_path_taken == PATH_REFL)
      else $error("zero Fresnel denominator did not reflect");

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("output beat valid right after reset");

endmodule
`default_nettype wire

[sv/frd_stage.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// frd_stage
// One register stage of the refraction pipeline. STAGE selects which slice
// of the arithmetic this stage applies to the item passing through.
// ----------------------------------------------------------------------------
module frd_stage #(
   parameter int STAGE     = 0,
   parameter int FRAC_BITS = 14
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 adv,
   input  logic                 in_valid,
   input  frd_pkg::frd_item_type in_item,
   output logic                 out_valid,
   output frd_pkg::frd_item_type out_item
);
   import frd_pkg::*;

   localparam int SHR = (2 * FRAC_BITS >= 30) ? 2 * FRAC_BITS - 30 : 0;
   localparam int SHL = (2 * FRAC_BITS < 30) ? 30 - 2 * FRAC_BITS : 0;
   localparam logic signed [63:0] CBIAS = (64'sd1 <<< SHR) - 64'sd1;
   localparam logic signed [63:0] C_LIM = 64'sd2147483648;
   localparam logic signed [40:0] ONE41 = 41'sd1073741824;
   localparam logic signed [40:0] SIN_MIN = -41'sd3221225472;
   localparam logic signed [53:0] OBIAS = 54'sd1073741823;
   localparam bit IS_ETA = (STAGE >= ST_ETA0) && (STAGE < ST_ETA0 + ETA_STEPS);
   localparam bit IS_SQ  = (STAGE >= ST_SQ0) && (STAGE < ST_SQ0 + SQ_STEPS);
   localparam bit IS_RAT = (STAGE >= ST_RAT0) && (STAGE < ST_RAT0 + RAT_STEPS);
   localparam int ETA_BIT  = IS_ETA ? 18 - (STAGE - ST_ETA0) : 0;
   localparam int SQ_SHIFT = IS_SQ ? 62 - 2 * (STAGE - ST_SQ0) : 0;

   function automatic logic [50:0] mag51(input logic signed [50:0] x);
      return x[50] ? 51'(-x) : 51'(x);
   endfunction

   frd_item_type        nxt;
   frd_item_type        item_ff;
   logic                valid_ff;

   logic [15:0]         d0;
   logic [34:0]         eta_num;
   logic [34:0]         eta_trial;
   logic signed [34:0]  dot;
   logic signed [34:0]  cneg;
   logic signed [63:0]  cshl;
   logic signed [63:0]  cwide;
   logic [31:0]         cmag;
   logic [63:0]         cc_full;
   logic [37:0]         eta_sq;
   logic [31:0]         smag;
   logic [37:0]         mm;
   logic signed [40:0]  sin2;
   logic signed [40:0]  u;
   logic [63:0]         sq_bit;
   logic [63:0]         sq_t;
   logic [31:0]         ct;
   logic [50:0]         ma;
   logic [50:0]         mb;
   logic [50:0]         pa;
   logic [50:0]         pb;
   logic [51:0]         r2;
   logic [51:0]         s2;
   logic [31:0]         ro;
   logic [31:0]         rp;
   logic [63:0]         sumsq;
   logic [63:0]         drawq;
   logic signed [53:0]  osum;
   logic signed [53:0]  oshift;
   logic signed [23:0]  tzs;

   always_comb begin
      nxt       = in_item;
      d0        = (in_item.n2 == 16'd0) ? 16'd1 : in_item.n2;
      eta_num   = {3'b0, in_item.n1, 16'b0};
      eta_trial = {19'b0, in_item.div_d} << ETA_BIT;
      dot       = $signed(in_item.prod[0]) + $signed(in_item.prod[1])
                + $signed(in_item.prod[2]);
      cneg      = -dot;
      cshl      = 64'(cneg) <<< SHL;
      cwide     = (cshl + (cshl < 0 ? CBIAS : 64'sd0)) >>> SHR;
      cmag      = in_item.c[32] ? 32'(-in_item.c) : 32'(in_item.c);
      cc_full   = cmag * cmag;
      eta_sq    = in_item.eta_q * in_item.eta_q;
      smag      = in_item.s[33] ? 32'(-in_item.s) : 32'(in_item.s);
      mm        = in_item.m[53:16];
      sin2      = in_item.s[33] ? -$signed({3'b0, mm}) : $signed({3'b0, mm});
      if (sin2 < SIN_MIN) begin
         sin2 = SIN_MIN;
      end
      u         = ONE41 - sin2;
      sq_bit    = 64'd1 << SQ_SHIFT;
      sq_t      = in_item.sq_res + sq_bit;
      ct        = in_item.sq_res[31:0];
      ma        = mag51(in_item.a_num);
      mb        = mag51(in_item.a_den);
      pa        = mag51(in_item.p_num);
      pb        = mag51(in_item.p_den);
      r2        = {in_item.ro_r[50:0], 1'b0};
      s2        = {in_item.rp_r[50:0], 1'b0};
      ro        = in_item.ro_sat ? 32'h8000_0000 : in_item.ro_q;
      rp        = in_item.rp_sat ? 32'h8000_0000 : in_item.rp_q;
      sumsq     = in_item.ro_sq + in_item.rp_sq;
      drawq     = {3'b0, in_item.draw, 45'b0};
      osum      = '0;
      oshift    = '0;
      tzs       = '0;

      if (STAGE == ST_IN) begin
         nxt.div_d   = d0;
         nxt.eta_rem = eta_num;
         nxt.eta_q   = '0;
         nxt.eta_sat = (eta_num >= ({19'b0, d0} << 19));
         for (int i = 0; i < 3; i++) begin
            nxt.prod[i] = $signed(in_item.v[i]) * $signed(in_item.n[i]);
         end
      end
      if (STAGE == ST_COS) begin
         if (cwide > C_LIM) begin
            nxt.c = 33'(C_LIM);
         end else if (cwide < -C_LIM) begin
            nxt.c = 33'(-C_LIM);
         end else begin
            nxt.c = 33'(cwide);
         end
      end
      if (STAGE == ST_CSQ) begin
         nxt.cc = cc_full[62:0];
      end
      if (STAGE == ST_S) begin
         nxt.s = 34'sd1073741824 - $signed({1'b0, in_item.cc[62:30]});
      end
      if (IS_ETA) begin
         if (in_item.eta_rem >= eta_trial) begin
            nxt.eta_rem        = in_item.eta_rem - eta_trial;
            nxt.eta_q[ETA_BIT] = 1'b1;
         end
      end
      if (STAGE == ST_ETA) begin
         if (in_item.eta_sat) begin
            nxt.eta_q = '1;
         end
      end
      if (STAGE == ST_ETA2) begin
         nxt.eta2 = eta_sq[37:16];
         nxt.ec   = $signed({1'b0, in_item.eta_q}) * in_item.c;
      end
      if (STAGE == ST_M) begin
         nxt.m    = in_item.eta2 * smag;
         nxt.ec_t = 36'((in_item.ec + (in_item.ec < 0 ? 52'sd65535 : 52'sd0)) >>> 16);
      end
      if (STAGE == ST_SIN) begin
         nxt.tir    = (sin2 > ONE41);
         nxt.sq_x   = {u[32:0], 30'b0};
         nxt.sq_res = '0;
      end
      if (IS_SQ) begin
         if ({1'b0, in_item.sq_x} >= sq_t) begin
            nxt.sq_x   = 63'({1'b0, in_item.sq_x} - sq_t);
            nxt.sq_res = (in_item.sq_res >> 1) + sq_bit;
         end else begin
            nxt.sq_res = in_item.sq_res >> 1;
         end
      end
      if (STAGE == ST_PROD4) begin
         nxt.p_n1c  = $signed({1'b0, in_item.n1}) * in_item.c;
         nxt.p_n2c  = $signed({1'b0, in_item.n2}) * in_item.c;
         nxt.p_n2ct = in_item.n2 * ct;
         nxt.p_n1ct = in_item.n1 * ct;
         nxt.k      = in_item.ec_t - $signed({4'b0, ct});
      end
      if (STAGE == ST_NUM) begin
         nxt.a_num = in_item.p_n1c - $signed({3'b0, in_item.p_n2ct});
         nxt.a_den = in_item.p_n1c + $signed({3'b0, in_item.p_n2ct});
         nxt.p_num = in_item.p_n2c - $signed({3'b0, in_item.p_n1ct});
         nxt.p_den = in_item.p_n2c + $signed({3'b0, in_item.p_n1ct});
      end
      if (STAGE == ST_RSET) begin
         nxt.zero_den = (in_item.a_den == '0) || (in_item.p_den == '0);
         nxt.ro_b     = mb;
         nxt.rp_b     = pb;
         nxt.ro_sat   = ({1'b0, ma} >= {mb, 1'b0});
         nxt.rp_sat   = ({1'b0, pa} >= {pb, 1'b0});
         nxt.ro_q     = {31'b0, (ma >= mb)};
         nxt.rp_q     = {31'b0, (pa >= pb)};
         nxt.ro_r     = {1'b0, ma} - ((ma >= mb) ? {1'b0, mb} : 52'd0);
         nxt.rp_r     = {1'b0, pa} - ((pa >= pb) ? {1'b0, pb} : 52'd0);
      end
      if (IS_RAT) begin
         nxt.ro_q = {in_item.ro_q[30:0], 1'b0};
         nxt.rp_q = {in_item.rp_q[30:0], 1'b0};
         nxt.ro_r = r2;
         nxt.rp_r = s2;
         if (r2 >= {1'b0, in_item.ro_b}) begin
            nxt.ro_r    = r2 - {1'b0, in_item.ro_b};
            nxt.ro_q[0] = 1'b1;
         end
         if (s2 >= {1'b0, in_item.rp_b}) begin
            nxt.rp_r    = s2 - {1'b0, in_item.rp_b};
            nxt.rp_q[0] = 1'b1;
         end
      end
      if (STAGE == ST_SQR) begin
         nxt.ro_sq = ro * ro;
         nxt.rp_sq = rp * rp;
      end
      if (STAGE == ST_PATH) begin
         priority if (in_item.tir) begin
            nxt.path = PATH_TIR;
         end else if (in_item.zero_den || (drawq < sumsq)) begin
            nxt.path = PATH_REFL;
         end else begin
            nxt.path = PATH_REFR;
         end
      end
      if (STAGE == ST_OPROD) begin
         for (int i = 0; i < 3; i++) begin
            nxt.pv[i] = $signed(in_item.v[i]) * $signed({1'b0, in_item.eta_q});
            nxt.pk[i] = $signed(in_item.n[i]) * in_item.k;
            nxt.pc[i] = $signed(in_item.n[i]) * in_item.c;
         end
      end
      if (STAGE == ST_OSUM) begin
         for (int i = 0; i < 3; i++) begin
            if (in_item.path == PATH_REFR) begin
               osum = (54'($signed(in_item.pv[i])) <<< 14) + 54'($signed(in_item.pk[i]));
            end else begin
               osum = (54'($signed(in_item.v[i])) <<< 30)
                    + (54'($signed(in_item.pc[i])) <<< 1);
            end
            oshift    = (osum + (osum < 0 ? OBIAS : 54'sd0)) >>> 30;
            nxt.tz[i] = oshift[23:0];
         end
      end
      if (STAGE == ST_OSAT) begin
         for (int i = 0; i < 3; i++) begin
            tzs = $signed(in_item.tz[i]);
            if (tzs > 24'sd32767) begin
               nxt.res[i] = 16'h7fff;
            end else if (tzs < -24'sd32768) begin
               nxt.res[i] = 16'h8000;
            end else begin
               nxt.res[i] = tzs[15:0];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (adv) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         item_ff <= nxt;
      end
   end

   assign out_valid = valid_ff;
   assign out_item  = item_ff;

endmodule
`default_nettype wire

[bench/tb_top.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tb_top
// Streams rays through the Fresnel refraction direction pipeline, predicts
// each outgoing direction and path in fixed point and checks every rsp beat
// in order, with random idling on both sides and one long receiver hold-off.
// ----------------------------------------------------------------------------

class ray_scoreboard;
   typedef struct {
      logic signed [15:0] x, y, z;
      logic [1:0]         path;
   } ray_result_type;

   ray_result_type pending[$];
   int             errors;

   static function longint abs64(longint x);
      return x < 0 ? -x : x;
   endfunction

   static function longint trunc_shr(longint x, int k);
      longint m;
      m = abs64(x) >>> k;
      return x < 0 ? -m : m;
   endfunction

   static function logic [15:0] clamp16(longint x);
      if (x > 32767) x = 32767;
      if (x < -32768) x = -32768;
      return x[15:0];
   endfunction

   static function longint unsigned root64(longint unsigned x);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > x) b = b >> 2;
      while (b != 0) begin
         if (x >= r + b) begin
            x = x - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   static function longint unsigned ratio_q30(longint num, longint den);
      longint unsigned a, b, q, r;
      a = abs64(num);
      b = abs64(den);
      if (a >= 2 * b) return 64'd1 << 31;
      q = (a >= b) ? 1 : 0;
      r = a - q * b;
      for (int i = 0; i < 30; i++) begin
         r = r << 1;
         q = q << 1;
         if (r >= b) begin
            r = r - b;
            q = q | 1;
         end
      end
      return q;
   endfunction

   function void note_ray(logic signed [15:0] vin[3], logic signed [15:0] nin[3],
                          logic [15:0] n1u, logic [15:0] n2u, logic [15:0] drawu);
      longint v[3], n[3], dot, c, s, sin2, ct, k, sum, n1, n2, an, ad, pn, pd;
      longint unsigned eta, eta2, m, u, ro, rp, draw;
      logic [1:0] path;
      ray_result_type e;
      const longint one = 64'sd1 << 30;
      dot = 0;
      for (int i = 0; i < 3; i++) begin
         v[i] = vin[i];
         n[i] = nin[i];
         dot += v[i] * n[i];
      end
      n1 = n1u;
      n2 = n2u;
      draw = drawu;
      c = -dot;
      c = c * 4;
      if (c > 2 * one) c = 2 * one;
      if (c < -2 * one) c = -2 * one;
      s = one - longint'(longint'(longint'(c * c)) >>> 30);
      eta = (longint'(n1) << 16) / (n2 != 0 ? n2 : 1);
      if (eta > (64'd1 << 19) - 1) eta = (64'd1 << 19) - 1;
      eta2 = (eta * eta) >> 16;
      m = (eta2 * longint'(abs64(s))) >> 16;
      sin2 = s < 0 ? -longint'(m) : longint'(m);
      if (sin2 < -3 * one) sin2 = -3 * one;
      ct = 0;
      if (sin2 > one) begin
         path = frd_pkg::PATH_TIR;
      end else begin
         u = one - sin2;
         ct = root64(u << 30);
         an = n1 * c - n2 * ct;
         ad = n1 * c + n2 * ct;
         pn = n2 * c - n1 * ct;
         pd = n2 * c + n1 * ct;
         if (ad == 0 || pd == 0) begin
            path = frd_pkg::PATH_REFL;
         end else begin
            ro = ratio_q30(an, ad);
            rp = ratio_q30(pn, pd);
            path = ((draw << 45) < ro * ro + rp * rp) ? frd_pkg::PATH_REFL
                                                      : frd_pkg::PATH_REFR;
         end
      end
      for (int i = 0; i < 3; i++) begin
         if (path == frd_pkg::PATH_REFR) begin
            k = trunc_shr(longint'(eta) * c, 16) - ct;
            sum = v[i] * longint'(eta) * 16384 + n[i] * k;
         end else begin
            sum = v[i] * one + 2 * n[i] * c;
         end
         if (i == 0) e.x = clamp16(trunc_shr(sum, 30));
         if (i == 1) e.y = clamp16(trunc_shr(sum, 30));
         if (i == 2) e.z = clamp16(trunc_shr(sum, 30));
      end
      e.path = path;
      pending.push_back(e);
   endfunction

   function void check_result(logic signed [15:0] x, logic signed [15:0] y,
                              logic signed [15:0] z, logic [1:0] path);
      ray_result_type e;
      if (pending.size() == 0) begin
         $display("%0t: unexpected rsp beat x=%0d y=%0d z=%0d path=%0d",
                  $time, x, y, z, path);
         errors++;
         return;
      end
      e = pending.pop_front();
      if (x !== e.x) begin
         $display("%0t: result_x expected %0d actual %0d", $time, e.x, x);
         errors++;
      end
      if (y !== e.y) begin
         $display("%0t: result_y expected %0d actual %0d", $time, e.y, y);
         errors++;
      end
      if (z !== e.z) begin
         $display("%0t: result_z expected %0d actual %0d", $time, e.z, z);
         errors++;
      end
      if (path !== e.path) begin
         $display("%0t: path_taken expected %0d actual %0d", $time, e.path, path);
         errors++;
      end
   endfunction
endclass

module tb_top;
   import frd_pkg::*;

   localparam int RANDOM_RAYS = 1500;
   localparam longint CYCLE_LIMIT = 400000;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic signed [15:0] req_incident_x = '0, req_incident_y = '0, req_incident_z = '0;
   logic signed [15:0] req_normal_x = '0, req_normal_y = '0, req_normal_z = '0;
   logic [15:0]        req_index_from = 16'd8192, req_index_to = 16'd8192;
   logic [15:0]        req_random_draw = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic signed [15:0] rsp_result_x, rsp_result_y, rsp_result_z;
   logic [1:0]         rsp_path_taken;

   ray_scoreboard rays = new();
   longint        cycle_count = 0;
   bit            quiet = 1'b0;
   bit            hold_done = 1'b0;
   int            sent = 0;

   fresnel_refract_direction_core i_dut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   // note accepted beats at the edge, using pre-edge values
   always @(posedge clock) begin
      logic signed [15:0] v[3], n[3];
      if (!reset && req_valid && req_ready) begin
         v[0] = req_incident_x; v[1] = req_incident_y; v[2] = req_incident_z;
         n[0] = req_normal_x; n[1] = req_normal_y; n[2] = req_normal_z;
         rays.note_ray(v, n, req_index_from, req_index_to, req_random_draw);
      end
      if (!reset && rsp_valid && rsp_ready)
         rays.check_result(rsp_result_x, rsp_result_y, rsp_result_z, rsp_path_taken);
   end

   // receiver: random stall bursts, one long hold-off, none at the end
   initial begin
      int n;
      @(posedge clock iff !reset);
      forever begin
         if (!hold_done && sent > 300) begin
            hold_done = 1'b1;
            rsp_ready <= 1'b0;
            repeat (300) @(posedge clock);
         end
         if (!quiet && $urandom_range(0, 3) == 0) begin
            n = $urandom_range(1, 13);
            rsp_ready <= 1'b0;
            repeat (n) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         n = $urandom_range(1, 20);
         repeat (n) @(posedge clock);
      end
   end

   task automatic send_ray(logic [15:0] ix, iy, iz, nx, ny, nz, n1, n2, dr);
      req_valid <= 1'b1;
      req_incident_x <= ix; req_incident_y <= iy; req_incident_z <= iz;
      req_normal_x <= nx; req_normal_y <= ny; req_normal_z <= nz;
      req_index_from <= n1; req_index_to <= n2; req_random_draw <= dr;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sent++;
      if (!quiet && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 13)) @(posedge clock);
      end
   endtask

   function automatic logic [15:0] rand_comp(bit unit_like);
      int r;
      if (!unit_like) return 16'($urandom_range(0, 65535));
      r = int'($urandom_range(0, 32768)) - 16384;
      return r[15:0];
   endfunction

   // roughly unit normal along a random axis with small tilt (fully random normal in mode 1)
   task automatic send_random_ray();
      logic [15:0] v[3], n[3], n1, n2;
      int axis, mode;
      mode = $urandom_range(0, 9);
      axis = $urandom_range(0, 2);
      for (int i = 0; i < 3; i++) begin
         n[i] = (i == axis) ? (($urandom_range(0, 1)) ? 16'sd16384 : -16'sd16384)
                            : 16'($signed($urandom_range(0, 2000)) - 1000);
         v[i] = rand_comp(mode == 0);
      end
      if (mode == 1) for (int i = 0; i < 3; i++) n[i] = rand_comp(0);
      n1 = (mode == 2) ? 16'($urandom_range(0, 65535)) : 16'($urandom_range(8192, 20000));
      n2 = (mode == 3) ? 16'($urandom_range(0, 65535)) : 16'($urandom_range(8192, 20000));
      send_ray(v[0], v[1], v[2], n[0], n[1], n[2], n1, n2, 16'($urandom_range(0, 65535)));
   endtask

   initial begin
      int wait_cycles;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // directed: normal incidence, grazing, TIR, extremes, zero index, zero denominators
      send_ray(16'sd0, 16'sd0, -16'sd16384, 16'sd0, 16'sd0, 16'sd16384, 16'd8192, 16'd12288, 16'd0);
      send_ray(16'sd0, 16'sd0, -16'sd16384, 16'sd0, 16'sd0, 16'sd16384, 16'd8192, 16'd12288, 16'hFFFF);
      send_ray(16'sd16384, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd16384, 16'd8192, 16'd8192, 16'd100);
      send_ray(16'sd11585, 16'sd0, -16'sd11585, 16'sd0, 16'sd0, 16'sd16384, 16'd12288, 16'd8192, 16'd0);
      send_ray(16'sd11585, 16'sd0, -16'sd11585, 16'sd0, 16'sd0, 16'sd16384, 16'd8192, 16'd12288, 16'd30000);
      send_ray(16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      send_ray(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh8000, 16'sh8000, 16'sh8000, 16'hFFFF, 16'd0, 16'd0);
      send_ray(16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'd0, 16'hFFFF, 16'h8000);
      send_ray(16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'd8192, 16'd8192, 16'd0);
      send_ray(16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'd0, 16'd0, 16'd0);
      send_ray(16'sd16384, 16'sd0, 16'sd0, 16'sd16384, 16'sd0, 16'sd0, 16'd0, 16'd8192, 16'd1);
      send_ray(16'sd0, 16'sd16384, 16'sd0, 16'sd0, 16'sd16384, 16'sd0, 16'd8192, 16'd0, 16'd1);
      send_ray(16'sd0, -16'sd16384, 16'sd0, 16'sd0, 16'sd16384, 16'sd0, 16'hFFFF, 16'd8192, 16'd0);
      send_ray(16'sd1, -16'sd1, 16'sd1, 16'sd1, 16'sd1, -16'sd1, 16'd8193, 16'd8191, 16'h5555);
      send_ray(16'shAAAA, 16'sh5555, 16'shAAAA, 16'sh5555, 16'shAAAA, 16'sh5555, 16'hAAAA, 16'h5555, 16'hAAAA);
      send_ray(16'sh5555, 16'shAAAA, 16'sh5555, 16'shAAAA, 16'sh5555, 16'shAAAA, 16'h5555, 16'hAAAA, 16'h5555);
      for (int i = 0; i < RANDOM_RAYS; i++) begin
         if (i == RANDOM_RAYS - 200) quiet = 1'b1;
         send_random_ray();
      end
      req_valid <= 1'b0;
      wait_cycles = 0;
      while (rays.pending.size() != 0 && wait_cycles < 20000) begin
         @(posedge clock);
         wait_cycles++;
      end
      repeat (150) @(posedge clock);
      if (rays.errors == 0 && rays.pending.size() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end
endmodule
`default_nettype wire
